// ===== src/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// MLFQ scheduler package
// Shared types, constants and codes of the feedback queue scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package mlfq_pkg;

  localparam int MaxTasks  = 64;
  localparam int Levels    = 3;
  localparam int IdW       = 6;
  localparam int CntW      = 7;
  localparam int LvlW      = 2;
  localparam int RingDepth = Levels * MaxTasks;
  localparam int RingAw    = 8;

  localparam logic [9:0]  QuantumReset = 10'd50;
  localparam logic [15:0] AllotReset   = 16'd200;

  typedef enum logic [1:0] {
    OP_ADMIT    = 2'd0,
    OP_DISPATCH = 2'd1,
    OP_BOOST    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BUSY   = 2'd2,
    ST_ZEROSV = 2'd3
  } status_e;

  localparam logic CfgQuantum = 1'b0;
  localparam logic CfgAllot   = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  task_id;
    logic [1:0]  task_type;
    logic [15:0] service_time;
    logic [6:0]  io_odds;
    logic [6:0]  io_draw;
    logic [9:0]  io_length;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] out_task;
    logic [1:0] out_type;
    logic [9:0] run_time;
    logic [9:0] busy_time;
    logic [1:0] level_after;
    logic       finished;
    logic       first_run;
  } out_word_t;

  // Per-slot task record, held in one memory.
  typedef struct packed {
    logic [15:0] remaining;
    logic [15:0] allot_left;
    logic [6:0]  odds;
    logic [1:0]  ttype;
    logic        never_run;
  } task_rec_t;

  localparam int RecW = $bits(task_rec_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;     // capture the input word
    logic adm_check;   // decide admit status
    logic adm_write;   // write record, push to level 0
    logic dsp_pick;    // choose level, read ring head
    logic dsp_empty;   // report nothing ready
    logic dsp_rdrec;   // read task record
    logic dsp_calc;    // compute run and write back
    logic bst_rd;      // read head of the level being drained
    logic bst_mv;      // move entry to level 0
    logic zero_out;    // produce all-zero ok result
    logic out_load;    // result register takes the word
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       adm_ok;
    logic       any_ready;
    logic       bst_more;
  } sts_t;

endpackage
`default_nettype wire

// ===== src/mlfq_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ===== src/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// MLFQ controller
// Sequences admit, dispatch and boost operations over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_ctrl
  import mlfq_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_ADM   = 9'b000000100,
    S_DRD   = 9'b000001000,
    S_DREC  = 9'b000010000,
    S_DCALC = 9'b000100000,
    S_BRD   = 9'b001000000,
    S_BMV   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;

  // The result register frees when its word is taken.
  logic out_free;
  assign out_free = !ovalid_q || !out_stall_i;

  always_comb begin
    state_d  = state_q;
    ovalid_d = ovalid_q;
    cmd_o    = '0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        case (sts_i.op)
          OP_ADMIT: begin
            cmd_o.adm_check = 1'b1;
            state_d = sts_i.adm_ok ? S_ADM : S_OUT;
          end
          OP_DISPATCH: begin
            if (sts_i.any_ready) begin
              cmd_o.dsp_pick = 1'b1;
              state_d = S_DRD;
            end else begin
              cmd_o.dsp_empty = 1'b1;
              state_d = S_OUT;
            end
          end
          OP_BOOST: begin
            cmd_o.zero_out = 1'b1;
            state_d = S_BRD;
          end
          default: begin
            cmd_o.zero_out = 1'b1;
            state_d = S_OUT;
          end
        endcase
      end
      S_ADM: begin
        cmd_o.adm_write = 1'b1;
        state_d = S_OUT;
      end
      S_DRD: begin
        cmd_o.dsp_rdrec = 1'b1;
        state_d = S_DREC;
      end
      S_DREC: begin
        state_d = S_DCALC;
      end
      S_DCALC: begin
        cmd_o.dsp_calc = 1'b1;
        state_d = S_OUT;
      end
      S_BRD: begin
        if (sts_i.bst_more) begin
          cmd_o.bst_rd = 1'b1;
          state_d = S_BMV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_BMV: begin
        cmd_o.bst_mv = 1'b1;
        state_d = S_BRD;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          ovalid_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
`default_nettype wire

// ===== src/mlfq_dp.sv =====
// ----------------------------------------------------------------------------
// MLFQ datapath
// Task record memory, level rings, configuration and run computation.
// ----------------------------------------------------------------------------
`default_nettype none
module mlfq_dp
  import mlfq_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire in_word_t   in_word_i,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  output out_word_t       out_word_o
);
  in_word_t   in_q;
  out_word_t  res_q, res_d, oword_q;
  logic [9:0]  quantum_q;
  logic [15:0] allot_q;
  logic [MaxTasks-1:0] used_q;
  logic [IdW-1:0]  head_q [Levels];
  logic [CntW-1:0] cnt_q  [Levels];
  logic [LvlW-1:0] lvl_q;     // level popped from
  logic [IdW-1:0]  slot_q;

  // Memories
  logic            rec_we, ring_we;
  logic [IdW-1:0]  rec_waddr;
  task_rec_t       rec_wdata, rec_rdata;
  logic [RingAw-1:0] ring_waddr, ring_raddr;
  logic [IdW-1:0]  ring_wdata, ring_rdata;

  // The record is read from the popped slot, so it is ready in the compute cycle.
  mlfq_ram #(.Width(RecW), .Depth(MaxTasks)) u_rec (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (slot_q),
    .rdata_o (rec_rdata)
  );

  mlfq_ram #(.Width(IdW), .Depth(RingDepth)) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (ring_raddr),
    .rdata_o (ring_rdata)
  );

  function automatic logic [RingAw-1:0] ring_addr(logic [LvlW-1:0] l, logic [IdW-1:0] p);
    return RingAw'(l) * RingAw'(MaxTasks) + RingAw'(p);
  endfunction

  // Highest-priority (lowest-numbered) non-empty level.
  logic [LvlW-1:0] pick_lvl;
  always_comb begin
    pick_lvl = LvlW'(Levels - 1);
    for (int l = Levels - 1; l >= 0; l--) begin
      if (cnt_q[l] != '0) pick_lvl = LvlW'(l);
    end
  end

  // Boost drains the highest non-empty level below level 0 first.
  logic [LvlW-1:0] blvl;
  always_comb begin
    blvl = LvlW'(Levels - 1);
    for (int l = Levels - 1; l >= 1; l--) begin
      if (cnt_q[l] != '0) blvl = LvlW'(l);
    end
  end

  // Run computation from the record read.
  logic [9:0]  io_time, qleft;
  logic [15:0] run, rem_new, all_new;
  logic [LvlW-1:0] new_lvl;
  always_comb begin
    io_time = '0;
    if ((in_q.io_draw < rec_rdata.odds) && (quantum_q != '0)) begin
      io_time = (in_q.io_length < quantum_q) ? in_q.io_length : quantum_q - 10'd1;
    end
    qleft = quantum_q - io_time;
    run = {6'd0, qleft};
    if (rec_rdata.remaining < run) run = rec_rdata.remaining;
    if (rec_rdata.allot_left < run) run = rec_rdata.allot_left;
    rem_new = rec_rdata.remaining - run;
    all_new = rec_rdata.allot_left - run;
    new_lvl = (lvl_q == LvlW'(Levels - 1)) ? lvl_q : lvl_q + LvlW'(1);
  end

  // Push target for memories.
  logic            push;
  logic [LvlW-1:0] push_lvl;
  logic [IdW-1:0]  push_slot;
  always_comb begin
    rec_we     = 1'b0;
    rec_waddr  = in_q.task_id;
    rec_wdata  = '0;
    push       = 1'b0;
    push_lvl   = '0;
    push_slot  = in_q.task_id;
    ring_raddr = ring_addr(blvl, head_q[blvl]);
    res_d      = res_q;
    if (cmd_i.adm_check) begin
      res_d = '0;
      res_d.out_task = in_q.task_id;
      if (used_q[in_q.task_id]) res_d.status = ST_BUSY;
      else if (in_q.service_time == '0) res_d.status = ST_ZEROSV;
    end
    if (cmd_i.adm_write) begin
      rec_we = 1'b1;
      rec_wdata.remaining  = in_q.service_time;
      rec_wdata.allot_left = allot_q;
      rec_wdata.odds       = in_q.io_odds;
      rec_wdata.ttype      = in_q.task_type;
      rec_wdata.never_run  = 1'b1;
      push = 1'b1;
    end
    if (cmd_i.dsp_pick) ring_raddr = ring_addr(pick_lvl, head_q[pick_lvl]);
    if (cmd_i.dsp_empty || cmd_i.zero_out) begin
      res_d = '0;
      if (cmd_i.dsp_empty) res_d.status = ST_EMPTY;
    end
    if (cmd_i.dsp_calc) begin
      rec_we    = 1'b1;
      rec_waddr = slot_q;
      rec_wdata.remaining  = rem_new;
      rec_wdata.allot_left = (all_new == '0) ? allot_q : all_new;
      rec_wdata.odds       = rec_rdata.odds;
      rec_wdata.ttype      = rec_rdata.ttype;
      rec_wdata.never_run  = 1'b0;
      res_d = '0;
      res_d.out_task  = slot_q;
      res_d.out_type  = rec_rdata.ttype;
      res_d.first_run = rec_rdata.never_run;
      res_d.run_time  = run[9:0];
      res_d.busy_time = run[9:0] + io_time;
      push_slot = slot_q;
      if (rem_new == '0) begin
        res_d.finished    = 1'b1;
        res_d.level_after = lvl_q;
      end else if (all_new == '0) begin
        push = 1'b1;
        push_lvl = new_lvl;
        res_d.level_after = new_lvl;
      end else begin
        push = 1'b1;
        push_lvl = lvl_q;
        res_d.level_after = lvl_q;
      end
    end
    if (cmd_i.bst_mv) begin
      push = 1'b1;
      push_slot = ring_rdata;
    end
    ring_we    = push;
    ring_wdata = push_slot;
    ring_waddr = ring_addr(push_lvl, head_q[push_lvl] + cnt_q[push_lvl][IdW-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) in_q <= in_word_i;
    if (cmd_i.dsp_pick) lvl_q <= pick_lvl;
    if (cmd_i.dsp_rdrec) slot_q <= ring_rdata;
    res_q <= res_d;
    if (cmd_i.out_load) oword_q <= res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QuantumReset;
      allot_q   <= AllotReset;
      used_q    <= '0;
      for (int l = 0; l < Levels; l++) begin
        head_q[l] <= '0;
        cnt_q[l]  <= '0;
      end
    end else begin
      if (cfg_we_i && cfg_index_i == CfgQuantum) quantum_q <= cfg_data_i[9:0];
      if (cfg_we_i && cfg_index_i == CfgAllot) allot_q <= cfg_data_i;
      if (cmd_i.adm_write) used_q[in_q.task_id] <= 1'b1;
      if (cmd_i.dsp_calc && rem_new == '0) used_q[slot_q] <= 1'b0;
      if (cmd_i.bst_rd) begin
        head_q[blvl] <= head_q[blvl] + IdW'(1);
        cnt_q[blvl]  <= cnt_q[blvl] - CntW'(1);
      end
      if (cmd_i.dsp_pick) begin
        head_q[pick_lvl] <= head_q[pick_lvl] + IdW'(1);
        cnt_q[pick_lvl]  <= cnt_q[pick_lvl] - CntW'(1);
      end
      if (push) cnt_q[push_lvl] <= cnt_q[push_lvl] + CntW'(1);
    end
  end

  logic any;
  always_comb begin
    any = 1'b0;
    for (int l = 0; l < Levels; l++) any = any | (cnt_q[l] != '0);
  end

  logic bmore;
  always_comb begin
    bmore = 1'b0;
    for (int l = 1; l < Levels; l++) bmore = bmore | (cnt_q[l] != '0);
  end

  assign sts_o.op        = in_q.op;
  assign sts_o.adm_ok    = !used_q[in_q.task_id] && (in_q.service_time != '0);
  assign sts_o.any_ready = any;
  assign sts_o.bst_more  = bmore;
  assign out_word_o      = oword_q;
endmodule
`default_nettype wire

// ===== src/mlfq_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// MLFQ task scheduler top level
// Three-level feedback queue scheduler with controller and datapath.
// ----------------------------------------------------------------------------
// Admit adds a record write if accepted; dispatch adds ring read, record read and
// compute unless none is ready; boost adds a read and a move per moved task.
// One word is in work at a time; the record and ring memories set the pace.
// The result register lets the next word enter while a result waits.
// Reset clears slot use, ring heads and counts, and loads default registers.
`default_nettype none
module mlfq_task_scheduler
  import mlfq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire in_word_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output out_word_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // With a stalled result the next word waits in the controller's output state.
  mlfq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mlfq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_word_o  (out_data_o)
  );
endmodule
`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// MLFQ scheduler testbench
// Drives admit, dispatch and boost words into the scheduler and checks every
// result against a behavioral copy of the queues, slots and registers.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import mlfq_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_word_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_word_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  mlfq_task_scheduler dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Scheduler state as predicted.
  logic [9:0]  quantum_q;
  logic [15:0] allot_q;
  logic        used_q[MaxTasks];
  logic [15:0] rem_q[MaxTasks];
  logic [15:0] left_q[MaxTasks];
  logic [6:0]  odds_q[MaxTasks];
  logic [1:0]  type_q[MaxTasks];
  logic        fresh_q[MaxTasks];
  logic [5:0]  level_q[Levels][$];

  in_word_t  pending_words[$];
  out_word_t expected_results[$];
  int        mismatches = 0;
  int        send_idle = 0;
  int        recv_idle = 0;
  bit        word_taken = 1'b0;

  function automatic out_word_t schedule_word(in_word_t w);
    out_word_t r;
    int lvl;
    logic [5:0] s;
    logic [9:0] io;
    logic [15:0] run;
    r = '0;
    case (op_e'(w.op))
      OP_ADMIT: begin
        r.out_task = w.task_id;
        if (used_q[w.task_id]) r.status = ST_BUSY;
        else if (w.service_time == 0) r.status = ST_ZEROSV;
        else begin
          used_q[w.task_id] = 1'b1;
          rem_q[w.task_id] = w.service_time;
          left_q[w.task_id] = allot_q;
          odds_q[w.task_id] = w.io_odds;
          type_q[w.task_id] = w.task_type;
          fresh_q[w.task_id] = 1'b1;
          level_q[0].push_back(w.task_id);
        end
      end
      OP_DISPATCH: begin
        lvl = 0;
        while (lvl < Levels && level_q[lvl].size() == 0) lvl++;
        if (lvl == Levels) r.status = ST_EMPTY;
        else begin
          s = level_q[lvl].pop_front();
          r.out_task = s;
          r.out_type = type_q[s];
          r.first_run = fresh_q[s];
          fresh_q[s] = 1'b0;
          io = '0;
          if (w.io_draw < odds_q[s] && quantum_q != 0)
            io = (w.io_length < quantum_q) ? w.io_length : quantum_q - 10'd1;
          run = 16'(quantum_q - io);
          if (rem_q[s] < run) run = rem_q[s];
          if (left_q[s] < run) run = left_q[s];
          rem_q[s] -= run;
          left_q[s] -= run;
          r.run_time = run[9:0];
          r.busy_time = run[9:0] + io;
          if (rem_q[s] == 0) begin
            used_q[s] = 1'b0;
            r.level_after = lvl[1:0];
            r.finished = 1'b1;
          end else if (left_q[s] == 0) begin
            if (lvl < Levels - 1) lvl++;
            left_q[s] = allot_q;
            level_q[lvl].push_back(s);
            r.level_after = lvl[1:0];
          end else begin
            level_q[lvl].push_back(s);
            r.level_after = lvl[1:0];
          end
        end
      end
      OP_BOOST: begin
        for (int l = 1; l < Levels; l++)
          while (level_q[l].size() != 0) level_q[0].push_back(level_q[l].pop_front());
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatches++;
  endtask

  // Driver: a waiting word is held until it has been taken at a rising edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || word_taken) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle) begin
          in_data_i <= pending_words[0];
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  // Monitor and input acceptance, sampled at the rising edge.
  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni) begin
      word_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        void'(pending_words.pop_front());
        expected_results.push_back(schedule_word(in_data_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) report_mismatch("unexpected result", 1, 0);
        else begin
          e = expected_results.pop_front();
          if (out_data_o.status != e.status)
            report_mismatch("status", out_data_o.status, e.status);
          if (out_data_o.out_task != e.out_task)
            report_mismatch("out_task", out_data_o.out_task, e.out_task);
          if (out_data_o.out_type != e.out_type)
            report_mismatch("out_type", out_data_o.out_type, e.out_type);
          if (out_data_o.run_time != e.run_time)
            report_mismatch("run_time", out_data_o.run_time, e.run_time);
          if (out_data_o.busy_time != e.busy_time)
            report_mismatch("busy_time", out_data_o.busy_time, e.busy_time);
          if (out_data_o.level_after != e.level_after)
            report_mismatch("level_after", out_data_o.level_after, e.level_after);
          if (out_data_o.finished != e.finished)
            report_mismatch("finished", out_data_o.finished, e.finished);
          if (out_data_o.first_run != e.first_run)
            report_mismatch("first_run", out_data_o.first_run, e.first_run);
        end
      end
    end
  end

  // Waits until every queued word has gone in and every result has come out.
  task automatic drain_words();
    while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid_i)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_register(logic idx, logic [15:0] value);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CfgQuantum) quantum_q = value[9:0];
    else allot_q = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic in_word_t make_word(op_e op, int id, int svc);
    in_word_t w;
    w.op = op;
    w.task_id = 6'(id);
    w.task_type = 2'($urandom_range(3));
    w.service_time = 16'(svc);
    w.io_odds = 7'($urandom_range(100));
    w.io_draw = 7'($urandom_range(100, 1));
    w.io_length = 10'($urandom_range(1022));
    return w;
  endfunction

  // A random phase: mostly admits and dispatches, now and then a boost,
  // with rare odd words. Slots mostly from a small set so busy slots occur.
  task automatic random_phase(int n);
    in_word_t w;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 35)
        w = make_word(OP_ADMIT, ($urandom_range(3) == 0) ? $urandom_range(63) :
                      $urandom_range(11),
                      ($urandom_range(19) == 0) ? 0 :
                      ($urandom_range(9) == 0) ? $urandom_range(65535) :
                      $urandom_range(400, 1));
      else if (pick < 92) w = make_word(OP_DISPATCH, $urandom_range(63), 0);
      else if (pick < 98) w = make_word(OP_BOOST, $urandom_range(63), 0);
      else w = make_word(OP_NONE, $urandom_range(63), $urandom_range(65535));
      if ($urandom_range(9) == 0) w.io_draw = 7'($urandom_range(127));
      if ($urandom_range(9) == 0) w.io_odds = 7'($urandom_range(127));
      pending_words.push_back(w);
    end
    drain_words();
  endtask

  initial begin
    in_word_t w;
    quantum_q = QuantumReset;
    allot_q = AllotReset;
    for (int i = 0; i < MaxTasks; i++) used_q[i] = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle = 28; recv_idle = 48;
    // Directed: empty dispatch, edge slots and fields, busy slot, zero time.
    pending_words.push_back(make_word(OP_DISPATCH, 0, 0));
    pending_words.push_back(make_word(OP_ADMIT, 0, 65535));
    pending_words.push_back(make_word(OP_ADMIT, 63, 1));
    pending_words.push_back(make_word(OP_ADMIT, 63, 5));
    pending_words.push_back(make_word(OP_ADMIT, 5, 0));
    w = make_word(OP_ADMIT, 42, 300);
    w.task_type = 2'd3;
    w.io_odds = 7'd100;
    pending_words.push_back(w);
    w = make_word(OP_DISPATCH, 0, 0);
    w.io_draw = 7'd1;
    w.io_length = 10'd1022;
    pending_words.push_back(w);
    w.io_draw = 7'd100;
    w.io_length = 10'd0;
    pending_words.push_back(w);
    pending_words.push_back(make_word(OP_NONE, 63, 65535));
    for (int i = 0; i < 10; i++) pending_words.push_back(make_word(OP_DISPATCH, 0, 0));
    pending_words.push_back(make_word(OP_BOOST, 0, 0));
    for (int i = 0; i < 4; i++) pending_words.push_back(make_word(OP_DISPATCH, 0, 0));
    drain_words();

    random_phase(300);
    write_register(CfgQuantum, 16'd1023);
    write_register(CfgAllot, 16'd1);
    random_phase(150);
    send_idle = 48; recv_idle = 28;
    write_register(CfgQuantum, 16'd1);
    write_register(CfgAllot, 16'd65535);
    random_phase(150);
    write_register(CfgQuantum, 16'd0);
    write_register(CfgAllot, 16'd0);
    random_phase(60);
    send_idle = 0; recv_idle = 0;
    write_register(CfgQuantum, 16'($urandom_range(200, 2)));
    write_register(CfgAllot, 16'($urandom_range(600, 1)));
    random_phase(540);

    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
src/mlfq_pkg.sv
src/mlfq_ram.sv
src/mlfq_ctrl.sv
src/mlfq_dp.sv
src/mlfq_task_scheduler.sv
test/tb.sv
